[rtl/cht_pkg.sv]
// Shared constants and types for the chained hash table.
`timescale 1ns / 1ps
`default_nettype none
package cht_pkg;
   localparam int BUCKETS    = 64;    // power of two: bucket is the low key bits
   localparam int POOL_NODES = 256;
   localparam int BKT_W  = $clog2(BUCKETS);
   localparam int IDX_W  = $clog2(POOL_NODES);
   localparam int LINK_W = IDX_W + 1;   // holds NIL
   localparam int CNT_W  = IDX_W + 1;
   localparam int KEY_W  = 32;
   localparam int VAL_W  = 32;
   localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_NODES);

   localparam logic [1:0] KIND_SET    = 2'd0;
   localparam logic [1:0] KIND_GET    = 2'd1;
   localparam logic [1:0] KIND_REMOVE = 2'd2;
   localparam logic [1:0] KIND_CLEAR  = 2'd3;

   typedef struct packed {
      logic [IDX_W-1:0]  rd_addr;
      logic              key_we;
      logic              val_we;
      logic [IDX_W-1:0]  wr_addr;
      logic [KEY_W-1:0]  key;
      logic [VAL_W-1:0]  val;
      logic              link_we;
      logic [IDX_W-1:0]  link_addr;
      logic [LINK_W-1:0] link;
   } node_cmd_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [VAL_W-1:0]  val;
      logic [LINK_W-1:0] link;
   } node_rd_type;
endpackage
`default_nettype wire

[rtl/cht_node_mem.sv]
// Node pool storage: key, value and link memories, with registered reads.
`timescale 1ns / 1ps
`default_nettype none
module cht_node_mem (
   input  wire logic                 clock,
   input  wire cht_pkg::node_cmd_type cmd,
   output cht_pkg::node_rd_type      rd
);
   logic [cht_pkg::KEY_W-1:0]  key_mem  [cht_pkg::POOL_NODES];
   logic [cht_pkg::VAL_W-1:0]  val_mem  [cht_pkg::POOL_NODES];
   logic [cht_pkg::LINK_W-1:0] link_mem [cht_pkg::POOL_NODES];

   always_ff @(posedge clock) begin
      if (cmd.key_we) begin
         key_mem[cmd.wr_addr] <= cmd.key;
      end
      if (cmd.val_we) begin
         val_mem[cmd.wr_addr] <= cmd.val;
      end
      if (cmd.link_we) begin
         link_mem[cmd.link_addr] <= cmd.link;
      end
      rd.key  <= key_mem[cmd.rd_addr];
      rd.val  <= val_mem[cmd.rd_addr];
      rd.link <= link_mem[cmd.rd_addr];
   end
endmodule
`default_nettype wire

[rtl/chained_hash_table_top.sv]
// Top level of the chained hash table: sequencer, bucket heads and free stack.
//
//   channel | dir | ports                                   | transaction
//   req     | in  | req_valid req_stall req_kind/key/value  | one operation
//   rsp     | out | rsp_valid rsp_stall rsp_found/old_value | one result
//           |     |   rsp_status rsp_table_empty            |
//
// One operation at a time. Clear goes straight to the result; get/remove/replace
// read the bucket head, walk the chain and apply, and an insert then writes the new
// node and may link it behind the tail; each chain step is one read of the node
// memory. Reset is synchronous and needs no clearing pass: bucket heads carry valid
// bits cleared at once by reset and by clear. req_stall is high from acceptance
// until the result transaction completes; a stalled result simply holds.
`timescale 1ns / 1ps
`default_nettype none
module chained_hash_table_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_kind,
   input  wire logic [31:0] req_key,
   input  wire logic [31:0] req_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_found,
   output logic [31:0]      rsp_old_value,
   output logic             rsp_status,
   output logic             rsp_table_empty
);
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_HEAD  = 3'd1;  // head read data ready
   localparam logic [2:0] ST_NODE  = 3'd2;  // node read data ready
   localparam logic [2:0] ST_ACT   = 3'd3;  // apply the operation
   localparam logic [2:0] ST_ALLOC = 3'd4;  // write the new node
   localparam logic [2:0] ST_LINK  = 3'd5;  // hook new node behind tail
   localparam logic [2:0] ST_RESP  = 3'd6;

   localparam int IW = cht_pkg::IDX_W;
   localparam int LW = cht_pkg::LINK_W;
   localparam int CW = cht_pkg::CNT_W;
   localparam int BW = cht_pkg::BKT_W;

   logic [2:0]   state_ff, state_in;
   logic [1:0]   kind_ff;
   logic [31:0]  key_ff, value_ff;
   logic [LW-1:0] cur_ff, cur_in, prev_ff, prev_in, link_ff, link_in, new_ff, new_in;
   logic         use_free_ff, use_free_in;
   logic         found_ff, found_in, status_ff, status_in;
   logic [31:0]  old_ff, old_in;
   logic [CW-1:0] free_top_ff, free_top_in, fresh_ff, fresh_in, entry_ff, entry_in;

   // bucket heads
   logic [IW-1:0] head_mem [cht_pkg::BUCKETS];
   logic [cht_pkg::BUCKETS-1:0] head_vld_ff;
   logic [IW-1:0] head_rd_ff;
   logic          head_vld_rd_ff;
   logic          head_we, head_set, head_clr;
   logic [LW-1:0] head_wdata;
   logic [BW-1:0] bkt;

   // free stack
   logic [IW-1:0] free_mem [cht_pkg::POOL_NODES];
   logic [IW-1:0] free_rd_ff;
   logic          free_rd_en, free_we;

   cht_pkg::node_cmd_type ncmd;
   cht_pkg::node_rd_type  nrd;
   logic [LW-1:0] head_cur, alloc_n;

   cht_node_mem u_node_mem (.clock(clock), .cmd(ncmd), .rd(nrd));

   assign bkt      = key_ff[BW-1:0];
   assign head_cur = head_vld_rd_ff ? {1'b0, head_rd_ff} : cht_pkg::NIL;
   assign alloc_n  = use_free_ff ? {1'b0, free_rd_ff} : new_ff;

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      prev_in     = prev_ff;
      link_in     = link_ff;
      new_in      = new_ff;
      use_free_in = use_free_ff;
      found_in    = found_ff;
      status_in   = status_ff;
      old_in      = old_ff;
      free_top_in = free_top_ff;
      fresh_in    = fresh_ff;
      entry_in    = entry_ff;
      head_we     = 1'b0;
      head_wdata  = cht_pkg::NIL;
      head_clr    = 1'b0;
      free_rd_en  = 1'b0;
      free_we     = 1'b0;
      ncmd        = '0;
      ncmd.rd_addr = cur_ff[IW-1:0];
      ncmd.wr_addr = cur_ff[IW-1:0];
      ncmd.key     = key_ff;
      ncmd.val     = value_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               found_in  = 1'b0;
               status_in = 1'b0;
               old_in    = '0;
               prev_in   = cht_pkg::NIL;
               if (req_kind == cht_pkg::KIND_CLEAR) begin
                  head_clr    = 1'b1;
                  free_top_in = '0;
                  fresh_in    = '0;
                  entry_in    = '0;
                  state_in    = ST_RESP;
               end else begin
                  state_in = ST_HEAD;
               end
            end
         end
         ST_HEAD: begin
            cur_in       = head_cur;
            ncmd.rd_addr = head_cur[IW-1:0];
            state_in     = (head_cur == cht_pkg::NIL) ? ST_ACT : ST_NODE;
         end
         ST_NODE: begin
            ncmd.rd_addr = nrd.link[IW-1:0];
            if (nrd.key == key_ff) begin
               found_in = 1'b1;
               old_in   = nrd.val;
               link_in  = nrd.link;
               state_in = ST_ACT;
            end else begin
               prev_in = cur_ff;
               cur_in  = nrd.link;
               if (nrd.link == cht_pkg::NIL) begin
                  state_in = ST_ACT;
               end
            end
         end
         ST_ACT: begin
            state_in = ST_RESP;
            if (kind_ff == cht_pkg::KIND_SET) begin
               if (found_ff) begin
                  ncmd.val_we = 1'b1;
               end else if (free_top_ff != '0) begin
                  free_rd_en  = 1'b1;
                  free_top_in = free_top_ff - 1'b1;
                  use_free_in = 1'b1;
                  state_in    = ST_ALLOC;
               end else if (fresh_ff < CW'(cht_pkg::POOL_NODES)) begin
                  new_in      = LW'(fresh_ff);
                  fresh_in    = fresh_ff + 1'b1;
                  use_free_in = 1'b0;
                  state_in    = ST_ALLOC;
               end else begin
                  status_in = 1'b1;
               end
            end else if (kind_ff == cht_pkg::KIND_REMOVE && found_ff) begin
               if (prev_ff == cht_pkg::NIL) begin
                  head_we    = 1'b1;
                  head_wdata = link_ff;
               end else begin
                  ncmd.link_we   = 1'b1;
                  ncmd.link_addr = prev_ff[IW-1:0];
                  ncmd.link      = link_ff;
               end
               if (free_top_ff < CW'(cht_pkg::POOL_NODES)) begin
                  free_we     = 1'b1;
                  free_top_in = free_top_ff + 1'b1;
               end
               if (entry_ff != '0) begin
                  entry_in = entry_ff - 1'b1;
               end
            end
         end
         ST_ALLOC: begin
            ncmd.wr_addr   = alloc_n[IW-1:0];
            ncmd.key_we    = 1'b1;
            ncmd.val_we    = 1'b1;
            ncmd.link_we   = 1'b1;
            ncmd.link_addr = alloc_n[IW-1:0];
            ncmd.link      = cht_pkg::NIL;
            entry_in       = entry_ff + 1'b1;
            new_in         = alloc_n;
            if (prev_ff == cht_pkg::NIL) begin
               head_we    = 1'b1;
               head_wdata = alloc_n;
               state_in   = ST_RESP;
            end else begin
               state_in = ST_LINK;
            end
         end
         ST_LINK: begin
            ncmd.link_we   = 1'b1;
            ncmd.link_addr = prev_ff[IW-1:0];
            ncmd.link      = new_ff;
            state_in       = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign head_set = head_we && (head_wdata != cht_pkg::NIL);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         free_top_ff <= '0;
         fresh_ff    <= '0;
         entry_ff    <= '0;
         head_vld_ff <= '0;
      end else begin
         state_ff    <= state_in;
         free_top_ff <= free_top_in;
         fresh_ff    <= fresh_in;
         entry_ff    <= entry_in;
         if (head_clr) begin
            head_vld_ff <= '0;
         end else if (head_we) begin
            head_vld_ff[bkt] <= head_set;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         kind_ff  <= req_kind;
         key_ff   <= req_key;
         value_ff <= req_value;
      end
      head_rd_ff     <= head_mem[req_key[BW-1:0]];
      head_vld_rd_ff <= head_vld_ff[req_key[BW-1:0]];
      if (head_set) begin
         head_mem[bkt] <= head_wdata[IW-1:0];
      end
      if (free_rd_en) begin
         free_rd_ff <= free_mem[free_top_in[IW-1:0]];
      end
      if (free_we) begin
         free_mem[free_top_ff[IW-1:0]] <= cur_ff[IW-1:0];
      end
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      link_ff     <= link_in;
      new_ff      <= new_in;
      use_free_ff <= use_free_in;
      found_ff    <= found_in;
      status_ff   <= status_in;
      old_ff      <= old_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = (state_ff == ST_RESP);
   assign rsp_found       = found_ff;
   assign rsp_old_value   = old_ff;
   assign rsp_status      = status_ff;
   assign rsp_table_empty = (entry_ff == '0);

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("result shown while accepting");
   a_walk_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NODE) |-> (cur_ff != cht_pkg::NIL)) else $error("walk past tail");
   a_entry_range: assert property (@(posedge clock) disable iff (reset)
      entry_ff <= CW'(cht_pkg::POOL_NODES)) else $error("entry count overflow");
   a_free_range: assert property (@(posedge clock) disable iff (reset)
      free_top_ff <= fresh_ff) else $error("free stack deeper than nodes used");
endmodule
`default_nettype wire

[bench/cht_checker.sv]
// Result checker for the chained hash table: mirrors the table and compares results.
`timescale 1ns / 1ps
module cht_checker
   import cht_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [1:0]  req_kind,
   input  wire logic [31:0] req_key,
   input  wire logic [31:0] req_value,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic        rsp_found,
   input  wire logic [31:0] rsp_old_value,
   input  wire logic        rsp_status,
   input  wire logic        rsp_table_empty,
   output int               fail_count,
   output int               pending_count
);
   typedef struct packed {
      logic        found;
      logic [31:0] old_value;
      logic        status;
      logic        table_empty;
   } lookup_result_type;

   // Chains kept as key lists per bucket, in insertion order.
   logic [31:0]       chain_keys[BUCKETS][$];
   logic [31:0]       chain_vals[BUCKETS][$];
   int                live_entries;
   lookup_result_type expected_q[$];

   function automatic lookup_result_type apply_op(logic [1:0] kind, logic [31:0] key,
                                                  logic [31:0] value);
      lookup_result_type r;
      int b;
      int pos;
      r = '0;
      b = int'(key % BUCKETS);
      pos = -1;
      if (kind == KIND_CLEAR) begin
         for (int i = 0; i < BUCKETS; i++) begin
            chain_keys[i].delete();
            chain_vals[i].delete();
         end
         live_entries = 0;
      end else begin
         for (int i = 0; i < chain_keys[b].size(); i++)
            if (pos < 0 && chain_keys[b][i] == key) pos = i;
         if (pos >= 0) begin
            r.found = 1'b1;
            r.old_value = chain_vals[b][pos];
         end
         if (kind == KIND_SET) begin
            if (pos >= 0) chain_vals[b][pos] = value;
            else if (live_entries >= POOL_NODES) r.status = 1'b1;
            else begin
               chain_keys[b].push_back(key);
               chain_vals[b].push_back(value);
               live_entries++;
            end
         end else if (kind == KIND_REMOVE && pos >= 0) begin
            chain_keys[b].delete(pos);
            chain_vals[b].delete(pos);
            live_entries--;
         end
      end
      r.table_empty = (live_entries == 0);
      return r;
   endfunction

   assign pending_count = expected_q.size();

   always @(posedge clock) begin
      lookup_result_type want;
      lookup_result_type got;
      if (reset) begin
         fail_count <= 0;
         live_entries = 0;
         expected_q.delete();
         for (int i = 0; i < BUCKETS; i++) begin
            chain_keys[i].delete();
            chain_vals[i].delete();
         end
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_found, rsp_old_value, rsp_status, rsp_table_empty};
            if (expected_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected result %p", got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (got !== want) begin
                  if (fail_count < 10) $display("mismatch: exp %p got %p", want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_q.push_back(apply_op(req_kind, req_key, req_value));
      end
   end
endmodule

[bench/tb.sv]
// Testbench top for the chained hash table: stimulus, stall pressure and verdict.
`timescale 1ns / 1ps
module tb;
   import cht_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_kind;
   logic [31:0] req_key;
   logic [31:0] req_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_found;
   logic [31:0] rsp_old_value;
   logic        rsp_status;
   logic        rsp_table_empty;
   int          fail_count;
   int          pending_count;
   int          sent_count;
   bit          long_hold;     // ask the receiver for one long stall

   chained_hash_table_top dut (.*);
   cht_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Send one transaction; valid held until accepted, dropped only before a gap.
   task automatic send_op(logic [1:0] kind, logic [31:0] key, logic [31:0] value);
      int gap;
      gap = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) gap = 0;   // stretches with no gaps
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_key   <= key;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      sent_count++;
   endtask

   // Stop offering and wait until every expected result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
   endtask

   // Random key that mostly lands in a small set so chains grow and hits are common.
   function automatic logic [31:0] pick_key(int spread);
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return {$urandom_range(0, 3) == 0 ? 26'h3FFFFFF : 26'd0, 6'($urandom())};
         default: return 32'($urandom_range(0, spread)) * BUCKETS
                         + 32'($urandom_range(0, 3));
      endcase
   endfunction

   // Receiver: stalls each result for a randomly drawn hold, plus one long hold-off on request.
   initial begin
      int hold;
      rsp_stall = 1'b1;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            repeat (300) @(posedge clock);
            long_hold = 1'b0;
         end
         while (!rsp_valid) @(posedge clock);
         hold = $urandom_range(0, 9);
         repeat (hold) @(posedge clock);
         rsp_stall <= 1'b0;
         @(posedge clock);
         rsp_stall <= 1'b1;
         @(posedge clock);
      end
   end

   initial begin
      logic [1:0] k;
      req_valid = 1'b0;
      req_kind  = KIND_GET;
      req_key   = '0;
      req_value = '0;
      reset     = 1'b1;
      sent_count = 0;
      long_hold = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty-table misses, extremes, replace, one-node chain miss, clear.
      send_op(KIND_GET, 32'hFFFF_FFFF, '0);
      send_op(KIND_REMOVE, 32'd0, '0);
      send_op(KIND_SET, 32'd0, 32'hFFFF_FFFF);
      send_op(KIND_SET, 32'hFFFF_FFC0, 32'd0);
      send_op(KIND_SET, 32'hFFFF_FFFF, 32'h5555_AAAA);
      send_op(KIND_SET, 32'd0, 32'hAAAA_5555);
      send_op(KIND_GET, 32'd0, '0);
      send_op(KIND_REMOVE, 32'd128, '0);
      send_op(KIND_REMOVE, 32'd0, '0);
      send_op(KIND_GET, 32'hFFFF_FFC0, '0);
      send_op(KIND_REMOVE, 32'd63, '0);
      send_op(KIND_REMOVE, 32'hFFFF_FFFF, '0);
      send_op(KIND_REMOVE, 32'hFFFF_FFC0, '0);
      send_op(KIND_SET, 32'd5, 32'd9);
      send_op(KIND_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_op(KIND_GET, 32'd5, '0);

      // Fill the pool past capacity: full sets, then a replace on a full pool.
      for (int i = 0; i < POOL_NODES + 4; i++)
         send_op(KIND_SET, 32'(i * 7), $urandom());
      send_op(KIND_SET, 32'd14, 32'h1234_5678);
      send_op(KIND_REMOVE, 32'd21, '0);
      send_op(KIND_SET, 32'hDEAD_BEEF, 32'd1);
      send_op(KIND_SET, 32'hDEAD_BEE0, 32'd2);

      // Long receiver hold-off while items keep coming.
      long_hold = 1'b1;
      for (int i = 0; i < 6; i++) send_op(KIND_GET, pick_key(20), '0);

      // Sender pause until all results are in.
      drain();
      send_op(KIND_CLEAR, '0, '0);

      // Random mix, weighted toward set/get/remove on clustered keys.
      for (int i = 0; i < 500; i++) begin
         case ($urandom_range(0, 99)) inside
            [0:44]:  k = KIND_SET;
            [45:69]: k = KIND_GET;
            [70:98]: k = KIND_REMOVE;
            default: k = KIND_CLEAR;
         endcase
         send_op(k, pick_key(i < 250 ? 8 : 40), $urandom());
      end
      drain();
      repeat (20) @(posedge clock);
      $display("Covered %0d operations: misses, replaces, pool overflow, clears,", sent_count);
      $display("chain removals and long result back-pressure.");
      if (fail_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end
endmodule
